// ===== design/jls_pkg.sv =====
package jls_pkg;

  // Job phases, numbered in lifecycle order.
  typedef enum logic [4:0] {
    PH_SESSION_CANDIDATE = 5'd0,
    PH_DESCRIBING        = 5'd1,
    PH_PLANNING          = 5'd2,
    PH_VERIFYING         = 5'd3,
    PH_ADMITTING         = 5'd4,
    PH_STARTING          = 5'd5,
    PH_RUNNING           = 5'd6,
    PH_INGRESS_CLOSED    = 5'd7,
    PH_DRAINING          = 5'd8,
    PH_FINALIZING        = 5'd9,
    PH_SINK_FLUSHING     = 5'd10,
    PH_CANCELLING        = 5'd11,
    PH_FAILING           = 5'd12,
    PH_TERMINAL_CLEANUP  = 5'd13,
    PH_COMPLETED         = 5'd14,
    PH_REJECTED          = 5'd15,
    PH_CANCELLED         = 5'd16,
    PH_FAILED            = 5'd17
  } phase_t;

  // Terminal cause; the encoding order is the priority order.
  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_CANCEL    = 2'd1,
    CAUSE_FAILURE   = 2'd2,
    CAUSE_INVARIANT = 2'd3
  } cause_t;

  typedef enum logic [3:0] {
    EV_DESCRIBE       = 4'd0,
    EV_PLAN           = 4'd1,
    EV_VERIFY         = 4'd2,
    EV_BEGIN_ADMIT    = 4'd3,
    EV_ADMIT          = 4'd4,
    EV_START          = 4'd5,
    EV_CLOSE_INGRESS  = 4'd6,
    EV_DRAIN          = 4'd7,
    EV_FINALIZE       = 4'd8,
    EV_SINK_FLUSH     = 4'd9,
    EV_COMPLETE       = 4'd10,
    EV_REJECT         = 4'd11,
    EV_CANCEL         = 4'd12,
    EV_FAIL           = 4'd13,
    EV_BEGIN_CLEANUP  = 4'd14,
    EV_FINISH_CLEANUP = 4'd15
  } event_t;

  typedef struct packed {
    phase_t phase;
    cause_t cause;
    logic   admitted;
  } job_state_t;

  localparam job_state_t STATE_RESET = '{
    phase:    PH_SESSION_CANDIDATE,
    cause:    CAUSE_NONE,
    admitted: 1'b0
  };

  function automatic logic phase_is_final(input phase_t p);
    return (p >= PH_COMPLETED);
  endfunction

  function automatic logic before_admission(input phase_t p);
    return (p <= PH_ADMITTING);
  endfunction

endpackage

// ===== design/jls_if.sv =====
interface jls_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic       inv_flag;

  modport source (output valid, output kind, output inv_flag, input ready);
  modport sink (input valid, input kind, input inv_flag, output ready);
endinterface

interface jls_out_if;
  logic       valid;
  logic       ready;
  logic       error;
  logic [4:0] phase_now;
  logic [1:0] cause_now;
  logic       admitted_now;
  logic       terminal_now;

  modport source (
    output valid, output error, output phase_now, output cause_now,
    output admitted_now, output terminal_now, input ready
  );
  modport sink (
    input valid, input error, input phase_now, input cause_now,
    input admitted_now, input terminal_now, output ready
  );
endinterface

// ===== design/job_lifecycle_sequencer.sv =====
// Job lifecycle sequencer.
// Each transfer on in_ch carries one lifecycle event (kind) and, for fail
// events, the invariant flag. For every event the block returns
// exactly one transfer on out_ch with the error flag, the phase after the
// event, the terminal cause, the admitted flag and whether the phase is
// terminal. An illegal event reports error and leaves the job state alone.
// An accepted event passes an input register and then a result register
// before it appears on out_ch.
// Throughput: one event per cycle while out_ch.ready stays high; the job state
// update is a single case decision on three small registers between those two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the job
// to session candidate with no cause and not admitted.
// When the receiver holds out_ch.ready low, the result stays put and one more
// event may still be taken into the input register; in_ch.ready then falls
// until the result drains.
module job_lifecycle_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  jls_in_if.sink    in_ch,
  jls_out_if.source out_ch
);

  // Input register: one accepted event waiting to be applied.
  logic             in_valid_r;
  jls_pkg::event_t  in_kind_r;
  logic             in_inv_r;

  // Result register and the job state it was computed against.
  logic             out_valid_r;
  logic             out_error_r;
  jls_pkg::phase_t  out_phase_r;
  jls_pkg::cause_t  out_cause_r;
  logic             out_admitted_r;
  logic             out_terminal_r;

  jls_pkg::job_state_t state_r;
  jls_pkg::job_state_t state_nxt;
  logic                step_error;
  logic                step_terminal;

  logic out_free;
  logic apply_evt;
  logic in_fire;

  // The result register can take a new value when it is empty or draining.
  assign out_free  = !out_valid_r || out_ch.ready;
  // The held event is applied to the state in the same cycle it moves on.
  assign apply_evt = in_valid_r && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_valid_r || out_free;

  jls_step u_step (
    .state_cur (state_r),
    .ev        (in_kind_r),
    .inv       (in_inv_r),
    .state_nxt (state_nxt),
    .error     (step_error),
    .terminal  (step_terminal)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_kind_r <= jls_pkg::event_t'(in_ch.kind);
      in_inv_r  <= in_ch.inv_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= jls_pkg::STATE_RESET;
    end else begin
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (apply_evt) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_evt) begin
      out_error_r    <= step_error;
      out_phase_r    <= state_nxt.phase;
      out_cause_r    <= state_nxt.cause;
      out_admitted_r <= state_nxt.admitted;
      out_terminal_r <= step_terminal;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.error        = out_error_r;
  assign out_ch.phase_now    = out_phase_r;
  assign out_ch.cause_now    = out_cause_r;
  assign out_ch.admitted_now = out_admitted_r;
  assign out_ch.terminal_now = out_terminal_r;

`ifndef SYNTHESIS
  // The terminal cause only ever rises outside reset.
  a_cause_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> state_r.cause >= $past(state_r.cause))
    else $error("terminal cause fell");

  // The admitted flag is never withdrawn outside reset.
  a_admitted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(state_r.admitted) |-> state_r.admitted)
    else $error("admitted flag cleared");

  // An illegal event leaves the job state exactly as it was.
  a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    apply_evt && step_error |=> $stable(state_r))
    else $error("illegal event changed the job state");
`endif

endmodule

// ===== design/jls_step.sv =====
module jls_step (
  input  jls_pkg::job_state_t state_cur,
  input  jls_pkg::event_t     ev,
  input  logic                inv,
  output jls_pkg::job_state_t state_nxt,
  output logic                error,
  output logic                terminal
);

  logic illegal;

  always_comb begin
    state_nxt = state_cur;
    illegal   = 1'b0;
    case (ev)
      jls_pkg::EV_DESCRIBE, jls_pkg::EV_PLAN, jls_pkg::EV_VERIFY,
      jls_pkg::EV_BEGIN_ADMIT, jls_pkg::EV_ADMIT, jls_pkg::EV_START,
      jls_pkg::EV_CLOSE_INGRESS, jls_pkg::EV_DRAIN, jls_pkg::EV_FINALIZE,
      jls_pkg::EV_SINK_FLUSH: begin
        // Each forward step is legal only from the phase with its own number.
        if (5'(state_cur.phase) == {1'b0, 4'(ev)}) begin
          state_nxt.phase = jls_pkg::phase_t'(5'(state_cur.phase) + 5'd1);
          if (ev == jls_pkg::EV_ADMIT) begin
            state_nxt.admitted = 1'b1;
          end
        end else begin
          illegal = 1'b1;
        end
      end
      jls_pkg::EV_COMPLETE: begin
        if (state_cur.phase == jls_pkg::PH_SINK_FLUSHING &&
            state_cur.cause == jls_pkg::CAUSE_NONE) begin
          state_nxt.phase = jls_pkg::PH_COMPLETED;
        end else begin
          illegal = 1'b1;
        end
      end
      jls_pkg::EV_REJECT: begin
        if (jls_pkg::before_admission(state_cur.phase)) begin
          state_nxt.phase = jls_pkg::PH_REJECTED;
        end else begin
          illegal = 1'b1;
        end
      end
      jls_pkg::EV_CANCEL: begin
        if (jls_pkg::phase_is_final(state_cur.phase)) begin
          illegal = 1'b1;
        end else if (jls_pkg::before_admission(state_cur.phase)) begin
          state_nxt.phase = jls_pkg::PH_CANCELLED;
        end else begin
          if (state_cur.cause < jls_pkg::CAUSE_CANCEL) begin
            state_nxt.cause = jls_pkg::CAUSE_CANCEL;
          end
          if (state_cur.phase != jls_pkg::PH_FAILING &&
              state_cur.phase != jls_pkg::PH_TERMINAL_CLEANUP) begin
            state_nxt.phase = jls_pkg::PH_CANCELLING;
          end
        end
      end
      jls_pkg::EV_FAIL: begin
        if (jls_pkg::phase_is_final(state_cur.phase)) begin
          illegal = 1'b1;
        end else begin
          if (inv) begin
            state_nxt.cause = jls_pkg::CAUSE_INVARIANT;
          end else if (state_cur.cause < jls_pkg::CAUSE_FAILURE) begin
            state_nxt.cause = jls_pkg::CAUSE_FAILURE;
          end
          if (state_cur.phase != jls_pkg::PH_TERMINAL_CLEANUP) begin
            state_nxt.phase = jls_pkg::PH_FAILING;
          end
        end
      end
      jls_pkg::EV_BEGIN_CLEANUP: begin
        if (state_cur.phase == jls_pkg::PH_CANCELLING ||
            state_cur.phase == jls_pkg::PH_FAILING) begin
          state_nxt.phase = jls_pkg::PH_TERMINAL_CLEANUP;
        end else begin
          illegal = 1'b1;
        end
      end
      jls_pkg::EV_FINISH_CLEANUP: begin
        if (state_cur.phase == jls_pkg::PH_TERMINAL_CLEANUP) begin
          state_nxt.phase = (state_cur.cause == jls_pkg::CAUSE_CANCEL) ?
                            jls_pkg::PH_CANCELLED : jls_pkg::PH_FAILED;
        end else begin
          illegal = 1'b1;
        end
      end
      default: begin
        illegal = 1'b1;
      end
    endcase
  end

  always_comb begin
    error    = illegal;
    terminal = jls_pkg::phase_is_final(state_nxt.phase);
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// One lifecycle event as it is offered on the input channel.
typedef struct packed {
  jls_pkg::event_t ev;
  logic            inv;
} job_step_t;

module tb;

  typedef struct packed {
    logic            error;
    jls_pkg::phase_t phase;
    jls_pkg::cause_t cause;
    logic            admitted;
    logic            terminal;
  } job_report_t;

  // Shapes of the lifecycle walked by the random part. The job never leaves a
  // terminal phase and reset is applied only once, so each run takes one path.
  typedef enum {
    ROUTE_COMPLETE,
    ROUTE_REJECT,
    ROUTE_EARLY_CANCEL,
    ROUTE_EARLY_FAIL,
    ROUTE_CANCELLED,
    ROUTE_ESCALATED
  } route_t;

  localparam int unsigned EVENT_COUNT = 1600;
  localparam int unsigned CALM_TAIL   = 200;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned WATCHDOG    = 400000;

  // Scoreboard: keeps its own copy of the job state, works out the expected
  // report for every accepted event and compares reports as they come out.
  class lifecycle_board;
    jls_pkg::job_state_t job;
    job_report_t         awaited[$];
    int unsigned         faults;
    int unsigned         seen;

    function new();
      job    = jls_pkg::STATE_RESET;
      faults = 0;
      seen   = 0;
    endfunction

    // Next state and report for one event applied to the given state.
    static function job_report_t advance_job(jls_pkg::job_state_t st,
                                             jls_pkg::event_t ev, logic inv);
      job_report_t     r;
      jls_pkg::phase_t ph;
      jls_pkg::cause_t cs;
      jls_pkg::cause_t lift;
      logic            adm;
      logic            bad;
      logic            ended;
      ph    = st.phase;
      cs    = st.cause;
      adm   = st.admitted;
      bad   = 1'b0;
      ended = ph inside {jls_pkg::PH_COMPLETED, jls_pkg::PH_REJECTED,
                         jls_pkg::PH_CANCELLED, jls_pkg::PH_FAILED};
      case (ev)
        jls_pkg::EV_COMPLETE: begin
          if (ph == jls_pkg::PH_SINK_FLUSHING && cs == jls_pkg::CAUSE_NONE)
            ph = jls_pkg::PH_COMPLETED;
          else bad = 1'b1;
        end
        jls_pkg::EV_REJECT: begin
          if (ph <= jls_pkg::PH_ADMITTING) ph = jls_pkg::PH_REJECTED;
          else bad = 1'b1;
        end
        jls_pkg::EV_CANCEL: begin
          if (ended) begin
            bad = 1'b1;
          end else if (ph <= jls_pkg::PH_ADMITTING) begin
            ph = jls_pkg::PH_CANCELLED;
          end else begin
            if (cs < jls_pkg::CAUSE_CANCEL) cs = jls_pkg::CAUSE_CANCEL;
            if (ph != jls_pkg::PH_FAILING && ph != jls_pkg::PH_TERMINAL_CLEANUP)
              ph = jls_pkg::PH_CANCELLING;
          end
        end
        jls_pkg::EV_FAIL: begin
          if (ended) begin
            bad = 1'b1;
          end else begin
            lift = inv ? jls_pkg::CAUSE_INVARIANT : jls_pkg::CAUSE_FAILURE;
            if (lift > cs) cs = lift;
            if (ph != jls_pkg::PH_TERMINAL_CLEANUP) ph = jls_pkg::PH_FAILING;
          end
        end
        jls_pkg::EV_BEGIN_CLEANUP: begin
          if (ph == jls_pkg::PH_CANCELLING || ph == jls_pkg::PH_FAILING)
            ph = jls_pkg::PH_TERMINAL_CLEANUP;
          else bad = 1'b1;
        end
        jls_pkg::EV_FINISH_CLEANUP: begin
          if (ph == jls_pkg::PH_TERMINAL_CLEANUP)
            ph = (cs == jls_pkg::CAUSE_CANCEL) ? jls_pkg::PH_CANCELLED
                                               : jls_pkg::PH_FAILED;
          else bad = 1'b1;
        end
        default: begin
          // Forward steps share their number with the phase they leave.
          if (ph == jls_pkg::phase_t'({1'b0, ev})) begin
            if (ev == jls_pkg::EV_ADMIT) adm = 1'b1;
            ph = jls_pkg::phase_t'(ph + 5'd1);
          end else begin
            bad = 1'b1;
          end
        end
      endcase
      r.error    = bad;
      r.phase    = ph;
      r.cause    = cs;
      r.admitted = adm;
      r.terminal = ph inside {jls_pkg::PH_COMPLETED, jls_pkg::PH_REJECTED,
                              jls_pkg::PH_CANCELLED, jls_pkg::PH_FAILED};
      return r;
    endfunction

    function void note_event(jls_pkg::event_t ev, logic inv);
      job_report_t r;
      r   = advance_job(job, ev, inv);
      job = '{phase: r.phase, cause: r.cause, admitted: r.admitted};
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH on result %0d: %s", $realtime, seen, msg);
      faults++;
    endtask

    task check_result(job_report_t got);
      job_report_t want;
      if (awaited.size() == 0) begin
        report($sformatf("report with no event outstanding (phase %0d)", got.phase));
      end else begin
        want = awaited.pop_front();
        if (got.error !== want.error)
          report($sformatf("error %b, expected %b", got.error, want.error));
        if (got.phase !== want.phase)
          report($sformatf("phase %0d, expected %0d", got.phase, want.phase));
        if (got.cause !== want.cause)
          report($sformatf("cause %0d, expected %0d", got.cause, want.cause));
        if (got.admitted !== want.admitted)
          report($sformatf("admitted %b, expected %b", got.admitted, want.admitted));
        if (got.terminal !== want.terminal)
          report($sformatf("terminal %b, expected %b", got.terminal, want.terminal));
      end
      seen++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  jls_in_if  in_ch ();
  jls_out_if out_ch ();

  job_lifecycle_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lifecycle_board board = new();

  // Requests from the event sender to the result receiver: one long hold-off
  // in the middle of the run, and no idling at all over the final stretch.
  bit hold_off_req = 1'b0;
  bit calm         = 1'b0;

  job_step_t route[$];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offer one event and hold it until the block takes it. The event is handed
  // to the scoreboard at the edge on which the transfer happens.
  task automatic offer(input job_step_t s);
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= s.ev;
    in_ch.inv_flag <= s.inv;
    do @(posedge clk); while (!in_ch.ready);
    board.note_event(s.ev, s.inv);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic void plan_step(input jls_pkg::event_t ev, input logic inv);
    route.push_back('{ev: ev, inv: inv});
  endfunction

  // A random event that is illegal in the given state, so it is reported as
  // an error and leaves the job where it is. Once the job is terminal every
  // event qualifies.
  function automatic job_step_t draw_stray(input jls_pkg::job_state_t st);
    job_step_t   s;
    job_report_t r;
    do begin
      s.ev  = jls_pkg::event_t'($urandom_range(0, 15));
      s.inv = 1'($urandom_range(0, 1));
      r     = lifecycle_board::advance_job(st, s.ev, s.inv);
    end while (!r.error);
    return s;
  endfunction

  // Lay out the legal events that carry the job along one lifecycle. The
  // later, cleanup-heavy shapes are favoured since they reach the most phases
  // and exercise the cause only ever rising.
  task automatic build_route();
    route_t      shape;
    int unsigned pick;
    int unsigned stop;
    int unsigned i;
    pick = $urandom_range(0, 9);
    if (pick < 4) shape = route_t'(pick);
    else if (pick < 7) shape = ROUTE_CANCELLED;
    else shape = ROUTE_ESCALATED;

    if (shape == ROUTE_COMPLETE) stop = jls_pkg::PH_SINK_FLUSHING;
    else if (shape inside {ROUTE_CANCELLED, ROUTE_ESCALATED})
      stop = $urandom_range(jls_pkg::PH_STARTING, jls_pkg::PH_SINK_FLUSHING);
    else stop = $urandom_range(jls_pkg::PH_SESSION_CANDIDATE, jls_pkg::PH_ADMITTING);

    // The invariant flag is randomised on every step: all events but fail
    // must ignore it.
    for (i = 0; i < stop; i++)
      plan_step(jls_pkg::event_t'(i), 1'($urandom_range(0, 1)));

    case (shape)
      ROUTE_COMPLETE: begin
        plan_step(jls_pkg::EV_COMPLETE, 1'($urandom_range(0, 1)));
      end
      ROUTE_REJECT: begin
        plan_step(jls_pkg::EV_REJECT, 1'($urandom_range(0, 1)));
      end
      ROUTE_EARLY_CANCEL: begin
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
      end
      ROUTE_EARLY_FAIL: begin
        plan_step(jls_pkg::EV_FAIL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_BEGIN_CLEANUP, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_FINISH_CLEANUP, 1'($urandom_range(0, 1)));
      end
      ROUTE_CANCELLED: begin
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_BEGIN_CLEANUP, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_FINISH_CLEANUP, 1'($urandom_range(0, 1)));
      end
      default: begin
        // Cancel first, then fail on top of it, cancel again while failing,
        // and raise the cause to invariant during cleanup.
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_FAIL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_BEGIN_CLEANUP, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_FAIL, 1'b1);
        plan_step(jls_pkg::EV_CANCEL, 1'($urandom_range(0, 1)));
        plan_step(jls_pkg::EV_FINISH_CLEANUP, 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // Event sender: reset, a short directed sweep, then the random lifecycle.
  initial begin : sender
    int          k;
    int unsigned n;
    int unsigned quota;
    int unsigned lingered;
    job_step_t   s;

    in_ch.valid    <= 1'b0;
    in_ch.kind     <= jls_pkg::EV_DESCRIBE;
    in_ch.inv_flag <= 1'b0;
    rst_n          <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sweep from session candidate: every event that is illegal
    // there, with the invariant flag toggling, must report an error and leave
    // the job untouched. Back-to-back transfers, no idling.
    for (k = jls_pkg::EV_PLAN; k <= jls_pkg::EV_FINISH_CLEANUP; k++) begin
      if (!(jls_pkg::event_t'(k) inside {jls_pkg::EV_REJECT, jls_pkg::EV_CANCEL,
                                         jls_pkg::EV_FAIL}))
        offer('{ev: jls_pkg::event_t'(k), inv: 1'(k)});
    end

    // Random part: in each phase a batch of illegal events with random
    // content, then the next legal step of the route. After the route ends
    // the job is terminal and every further event must be refused.
    build_route();
    quota    = $urandom_range(30, 80);
    lingered = 0;
    for (n = 0; n < EVENT_COUNT; n++) begin
      if (route.size() != 0 && lingered >= quota) begin
        s        = route.pop_front();
        quota    = $urandom_range(30, 80);
        lingered = 0;
      end else begin
        s = draw_stray(board.job);
        lingered++;
      end

      if (n == EVENT_COUNT / 3) begin
        // The receiver stalls for a long stretch while events keep coming,
        // so the block fills up and drops in_ch.ready.
        hold_off_req = 1'b1;
      end else if (n == EVENT_COUNT / 2) begin
        // Let everything outstanding drain before carrying on.
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.awaited.size() != 0);
      end else if (n == EVENT_COUNT - CALM_TAIL) begin
        calm = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pause_sender($urandom_range(1, 13));
      end
      offer(s);
    end

    // Wait for every outstanding report, then let the bench run on to catch
    // anything the block might still emit on its own.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (board.faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result receiver: ready in random stretches with random stalls, one long
  // hold-off on request, and steady ready over the calm tail.
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Every report transfer is checked against the oldest expectation. The
  // values read here are those present just before the edge.
  always @(posedge clk) begin : watch_results
    job_report_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.error    = out_ch.error;
      got.phase    = jls_pkg::phase_t'(out_ch.phase_now);
      got.cause    = jls_pkg::cause_t'(out_ch.cause_now);
      got.admitted = out_ch.admitted_now;
      got.terminal = out_ch.terminal_now;
      board.check_result(got);
    end
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin : watchdog
    repeat (WATCHDOG) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
